// ===== sv/i2cmbe_pkg.sv =====
// types and constants shared by the i2c master byte engine
`default_nettype none

package i2cmbe_pkg;

   localparam int unsigned CFG_WIDTH = 10;
   localparam logic [CFG_WIDTH-1:0] BIT_DELAY_RESET = 10'd10;

   // command codes on the req_type field
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_STOP  = 2'd3;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic       cmd_valid;
      logic [1:0] req_type;
      logic [7:0] cmd_byte;
      logic       read_flag;
      logic       last_byte;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl_low;
      logic       sda_low;
      logic       busy_res;
      logic       done_res;
      logic       ack_ok;
      logic [7:0] read_data;
   } rsp_item_type;

   typedef enum logic [18:0] {
      PH_IDLE      = 19'h00001,
      PH_ST_SCL    = 19'h00002,
      PH_TX_DATA   = 19'h00004,
      PH_TX_CLKHI  = 19'h00008,
      PH_TX_CLKLO  = 19'h00010,
      PH_RA_REL    = 19'h00020,
      PH_RA_CLKHI  = 19'h00040,
      PH_RA_SAMPLE = 19'h00080,
      PH_RA_END    = 19'h00100,
      PH_RX_REL    = 19'h00200,
      PH_RX_CLKHI  = 19'h00400,
      PH_RX_SAMPLE = 19'h00800,
      PH_TA_DATA   = 19'h01000,
      PH_TA_CLKHI  = 19'h02000,
      PH_TA_CLKLO  = 19'h04000,
      PH_TA_END    = 19'h08000,
      PH_SP_SCL    = 19'h10000,
      PH_SP_SDA    = 19'h20000,
      PH_SP_END    = 19'h40000
   } phase_type;

endpackage

`default_nettype wire

// ===== sv/i2cmbe_req_if.sv =====
// request channel: valid/ready handshake with one tick of command and line input
`default_nettype none

interface i2cmbe_req_if;
   logic                     valid;
   logic                     ready;
   i2cmbe_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/i2cmbe_rsp_if.sv =====
// response channel: valid/ready handshake with one tick of line drive and status
`default_nettype none

interface i2cmbe_rsp_if;
   logic                     valid;
   logic                     ready;
   i2cmbe_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/i2c_master_byte_engine_unit.sv =====
// i2c master byte engine top level: request register, sequencer, response register
// a request is held in the request register and its response in the response register
// throughput: one request per cycle while responses are taken; each request is one bus tick of the sequencer
// a stalled response holds the sequencer; one more request fits in the request
// register, after that req_ch.ready stays low until the response is taken
// reset: synchronous; sequencer goes idle with both lines released, bit_delay is 10
`default_nettype none

module i2c_master_byte_engine_unit #(
   parameter int unsigned DELAY_WIDTH = 10
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   i2cmbe_req_if.sink                            req_ch,
   i2cmbe_rsp_if.source                          rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [i2cmbe_pkg::CFG_WIDTH-1:0] csr_wdata
);

   logic                                 in_valid_ff, in_valid_in;
   i2cmbe_pkg::req_item_type             in_item_ff, in_item_in;
   logic                                 out_valid_ff, out_valid_in;
   i2cmbe_pkg::rsp_item_type             out_item_ff, out_item_in;
   logic [i2cmbe_pkg::CFG_WIDTH-1:0]     bit_delay_ff, bit_delay_in;

   i2cmbe_pkg::rsp_item_type step_result;
   logic                     step;
   logic                     req_take;

   // the held request advances when the response register is free or draining
   assign step     = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !step);
      in_item_in   = req_take ? req_ch.data : in_item_ff;
      out_valid_in = step || (out_valid_ff && !rsp_ch.ready);
      out_item_in  = step ? step_result : out_item_ff;
      bit_delay_in = csr_we ? csr_wdata : bit_delay_ff;
   end

   i2cmbe_seq #(
      .DELAY_WIDTH (DELAY_WIDTH)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_item_ff),
      .bit_delay (bit_delay_ff),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         bit_delay_ff <= i2cmbe_pkg::BIT_DELAY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         bit_delay_ff <= bit_delay_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_item_ff;

endmodule

`default_nettype wire

// ===== sv/i2cmbe_seq.sv =====
// bus sequencer: state registers and the single-tick step logic
`default_nettype none

module i2cmbe_seq #(
   parameter int unsigned DELAY_WIDTH = 10
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 step,
   input  wire i2cmbe_pkg::req_item_type             item,
   input  wire logic [i2cmbe_pkg::CFG_WIDTH-1:0]     bit_delay,
   output i2cmbe_pkg::rsp_item_type                  result
);

   i2cmbe_pkg::phase_type   phase_ff, phase_in;
   logic [3:0]              bit_count_ff, bit_count_in;
   logic [7:0]              shift_ff, shift_in;
   logic [DELAY_WIDTH-1:0]  wait_ff, wait_in;
   logic                    nack_ff, nack_in;
   logic                    scl_drv_ff, scl_drv_in;
   logic                    sda_drv_ff, sda_drv_in;

   // bit_delay limited or zero-extended to the counter width
   logic [DELAY_WIDTH+i2cmbe_pkg::CFG_WIDTH-1:0] delay_ext;
   logic [DELAY_WIDTH-1:0]                        delay;
   assign delay_ext = {{DELAY_WIDTH{1'b0}}, bit_delay};
   assign delay     = delay_ext[DELAY_WIDTH-1:0];

   logic       done;
   logic       ack;
   logic [7:0] rdata;
   logic [3:0] bit_count_inc;

   assign bit_count_inc = bit_count_ff + 4'd1;

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      wait_in      = wait_ff;
      nack_in      = nack_ff;
      scl_drv_in   = scl_drv_ff;
      sda_drv_in   = sda_drv_ff;
      done         = 1'b0;
      ack          = 1'b0;
      rdata        = 8'd0;

      if (phase_ff == i2cmbe_pkg::PH_IDLE) begin
         if (item.cmd_valid) begin
            bit_count_in = 4'd0;
            case (item.req_type)
               i2cmbe_pkg::CMD_START: begin
                  shift_in   = {item.cmd_byte[6:0], item.read_flag};
                  sda_drv_in = 1'b1;
                  phase_in   = i2cmbe_pkg::PH_ST_SCL;
                  wait_in    = delay;
               end
               i2cmbe_pkg::CMD_WRITE: begin
                  shift_in = item.cmd_byte;
                  phase_in = i2cmbe_pkg::PH_TX_DATA;
                  wait_in  = '0;
               end
               i2cmbe_pkg::CMD_READ: begin
                  shift_in = 8'd0;
                  nack_in  = item.last_byte;
                  phase_in = i2cmbe_pkg::PH_RX_REL;
                  wait_in  = '0;
               end
               default: begin
                  sda_drv_in = 1'b1;
                  phase_in   = i2cmbe_pkg::PH_SP_SCL;
                  wait_in    = delay;
               end
            endcase
         end
      end else if (wait_ff > DELAY_WIDTH'(1)) begin
         wait_in = wait_ff - DELAY_WIDTH'(1);
      end else begin
         wait_in = '0;
         case (phase_ff)
            i2cmbe_pkg::PH_ST_SCL: begin
               scl_drv_in = 1'b1;
               phase_in   = i2cmbe_pkg::PH_TX_DATA;
            end
            i2cmbe_pkg::PH_TX_DATA: begin
               sda_drv_in = ~shift_ff[7];
               phase_in   = i2cmbe_pkg::PH_TX_CLKHI;
            end
            i2cmbe_pkg::PH_TX_CLKHI: begin
               scl_drv_in = 1'b0;
               phase_in   = i2cmbe_pkg::PH_TX_CLKLO;
               wait_in    = delay;
            end
            i2cmbe_pkg::PH_TX_CLKLO: begin
               scl_drv_in   = 1'b1;
               shift_in     = {shift_ff[6:0], 1'b0};
               bit_count_in = bit_count_inc;
               phase_in     = (bit_count_inc >= i2cmbe_pkg::BITS_PER_BYTE) ?
                              i2cmbe_pkg::PH_RA_REL : i2cmbe_pkg::PH_TX_DATA;
            end
            i2cmbe_pkg::PH_RA_REL: begin
               sda_drv_in = 1'b0;
               phase_in   = i2cmbe_pkg::PH_RA_CLKHI;
            end
            i2cmbe_pkg::PH_RA_CLKHI: begin
               scl_drv_in = 1'b0;
               phase_in   = i2cmbe_pkg::PH_RA_SAMPLE;
               wait_in    = delay;
            end
            i2cmbe_pkg::PH_RA_SAMPLE: begin
               nack_in    = item.sda_in;
               scl_drv_in = 1'b1;
               phase_in   = i2cmbe_pkg::PH_RA_END;
               wait_in    = delay;
            end
            i2cmbe_pkg::PH_RA_END: begin
               sda_drv_in = 1'b1;
               done       = 1'b1;
               ack        = ~nack_ff;
               phase_in   = i2cmbe_pkg::PH_IDLE;
            end
            i2cmbe_pkg::PH_RX_REL: begin
               sda_drv_in = 1'b0;
               phase_in   = i2cmbe_pkg::PH_RX_CLKHI;
               wait_in    = delay;
            end
            i2cmbe_pkg::PH_RX_CLKHI: begin
               scl_drv_in = 1'b0;
               phase_in   = i2cmbe_pkg::PH_RX_SAMPLE;
               wait_in    = delay;
            end
            i2cmbe_pkg::PH_RX_SAMPLE: begin
               shift_in     = {shift_ff[6:0], item.sda_in};
               scl_drv_in   = 1'b1;
               bit_count_in = bit_count_inc;
               if (bit_count_inc >= i2cmbe_pkg::BITS_PER_BYTE) begin
                  phase_in = i2cmbe_pkg::PH_TA_DATA;
               end else begin
                  phase_in = i2cmbe_pkg::PH_RX_CLKHI;
                  wait_in  = delay;
               end
            end
            i2cmbe_pkg::PH_TA_DATA: begin
               // nack leaves sda released, ack pulls it low
               sda_drv_in = ~nack_ff;
               phase_in   = i2cmbe_pkg::PH_TA_CLKHI;
            end
            i2cmbe_pkg::PH_TA_CLKHI: begin
               scl_drv_in = 1'b0;
               phase_in   = i2cmbe_pkg::PH_TA_CLKLO;
               wait_in    = delay;
            end
            i2cmbe_pkg::PH_TA_CLKLO: begin
               scl_drv_in = 1'b1;
               phase_in   = i2cmbe_pkg::PH_TA_END;
               wait_in    = delay;
            end
            i2cmbe_pkg::PH_TA_END: begin
               sda_drv_in = 1'b1;
               done       = 1'b1;
               rdata      = shift_ff;
               phase_in   = i2cmbe_pkg::PH_IDLE;
            end
            i2cmbe_pkg::PH_SP_SCL: begin
               scl_drv_in = 1'b0;
               phase_in   = i2cmbe_pkg::PH_SP_SDA;
               wait_in    = delay;
            end
            i2cmbe_pkg::PH_SP_SDA: begin
               sda_drv_in = 1'b0;
               phase_in   = i2cmbe_pkg::PH_SP_END;
               wait_in    = delay;
            end
            i2cmbe_pkg::PH_SP_END: begin
               done     = 1'b1;
               phase_in = i2cmbe_pkg::PH_IDLE;
            end
            default: begin
               phase_in = i2cmbe_pkg::PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= i2cmbe_pkg::PH_IDLE;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'd0;
         wait_ff      <= '0;
         nack_ff      <= 1'b0;
         scl_drv_ff   <= 1'b0;
         sda_drv_ff   <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         wait_ff      <= wait_in;
         nack_ff      <= nack_in;
         scl_drv_ff   <= scl_drv_in;
         sda_drv_ff   <= sda_drv_in;
      end
   end

   always_comb begin
      result.scl_low   = scl_drv_in;
      result.sda_low   = sda_drv_in;
      result.busy_res  = (phase_in != i2cmbe_pkg::PH_IDLE);
      result.done_res  = done;
      result.ack_ok    = ack;
      result.read_data = rdata;
   end

endmodule

`default_nettype wire

// ===== tb/i2c_master_byte_engine_unit_tb.sv =====
// testbench for the i2c master byte engine: bus tick stimulus checked against a shadow sequencer
`default_nettype none

module i2c_master_byte_engine_unit_tb;

   class engine_shadow;
      logic [i2cmbe_pkg::CFG_WIDTH-1:0] bit_delay;
      i2cmbe_pkg::phase_type            phase;
      logic [3:0]                       bit_count;
      logic [7:0]                       shift_reg;
      logic [i2cmbe_pkg::CFG_WIDTH-1:0] wait_count;
      logic                             nack_pending;
      logic                             scl_drive;
      logic                             sda_drive;
      i2cmbe_pkg::rsp_item_type         bus_outputs_q[$];
      int                               errors;

      function new();
         bit_delay    = i2cmbe_pkg::BIT_DELAY_RESET;
         phase        = i2cmbe_pkg::PH_IDLE;
         bit_count    = '0;
         shift_reg    = '0;
         wait_count   = '0;
         nack_pending = 1'b0;
         scl_drive    = 1'b0;
         sda_drive    = 1'b0;
         errors       = 0;
      endfunction

      function void enter(i2cmbe_pkg::phase_type nxt, bit timed);
         phase      = nxt;
         wait_count = timed ? bit_delay : '0;
      endfunction

      function i2cmbe_pkg::rsp_item_type advance_tick(i2cmbe_pkg::req_item_type r);
         i2cmbe_pkg::rsp_item_type o;
         o = '0;
         if (phase == i2cmbe_pkg::PH_IDLE) begin
            if (r.cmd_valid) begin
               bit_count = '0;
               case (r.req_type)
                  i2cmbe_pkg::CMD_START: begin
                     shift_reg = {r.cmd_byte[6:0], r.read_flag};
                     sda_drive = 1'b1;
                     enter(i2cmbe_pkg::PH_ST_SCL, 1'b1);
                  end
                  i2cmbe_pkg::CMD_WRITE: begin
                     shift_reg = r.cmd_byte;
                     enter(i2cmbe_pkg::PH_TX_DATA, 1'b0);
                  end
                  i2cmbe_pkg::CMD_READ: begin
                     shift_reg    = '0;
                     nack_pending = r.last_byte;
                     enter(i2cmbe_pkg::PH_RX_REL, 1'b0);
                  end
                  default: begin
                     sda_drive = 1'b1;
                     enter(i2cmbe_pkg::PH_SP_SCL, 1'b1);
                  end
               endcase
            end
         end else if (wait_count > 1) begin
            wait_count = wait_count - 1'b1;
         end else begin
            case (phase)
               i2cmbe_pkg::PH_ST_SCL: begin
                  scl_drive = 1'b1;
                  enter(i2cmbe_pkg::PH_TX_DATA, 1'b0);
               end
               i2cmbe_pkg::PH_TX_DATA: begin
                  sda_drive = !shift_reg[7];
                  enter(i2cmbe_pkg::PH_TX_CLKHI, 1'b0);
               end
               i2cmbe_pkg::PH_TX_CLKHI: begin
                  scl_drive = 1'b0;
                  enter(i2cmbe_pkg::PH_TX_CLKLO, 1'b1);
               end
               i2cmbe_pkg::PH_TX_CLKLO: begin
                  scl_drive = 1'b1;
                  shift_reg = {shift_reg[6:0], 1'b0};
                  bit_count = bit_count + 1'b1;
                  if (bit_count >= i2cmbe_pkg::BITS_PER_BYTE)
                     enter(i2cmbe_pkg::PH_RA_REL, 1'b0);
                  else enter(i2cmbe_pkg::PH_TX_DATA, 1'b0);
               end
               i2cmbe_pkg::PH_RA_REL: begin
                  sda_drive = 1'b0;
                  enter(i2cmbe_pkg::PH_RA_CLKHI, 1'b0);
               end
               i2cmbe_pkg::PH_RA_CLKHI: begin
                  scl_drive = 1'b0;
                  enter(i2cmbe_pkg::PH_RA_SAMPLE, 1'b1);
               end
               i2cmbe_pkg::PH_RA_SAMPLE: begin
                  nack_pending = r.sda_in;
                  scl_drive    = 1'b1;
                  enter(i2cmbe_pkg::PH_RA_END, 1'b1);
               end
               i2cmbe_pkg::PH_RA_END: begin
                  sda_drive  = 1'b1;
                  o.done_res = 1'b1;
                  o.ack_ok   = !nack_pending;
                  enter(i2cmbe_pkg::PH_IDLE, 1'b0);
               end
               i2cmbe_pkg::PH_RX_REL: begin
                  sda_drive = 1'b0;
                  enter(i2cmbe_pkg::PH_RX_CLKHI, 1'b1);
               end
               i2cmbe_pkg::PH_RX_CLKHI: begin
                  scl_drive = 1'b0;
                  enter(i2cmbe_pkg::PH_RX_SAMPLE, 1'b1);
               end
               i2cmbe_pkg::PH_RX_SAMPLE: begin
                  shift_reg = {shift_reg[6:0], r.sda_in};
                  scl_drive = 1'b1;
                  bit_count = bit_count + 1'b1;
                  if (bit_count >= i2cmbe_pkg::BITS_PER_BYTE)
                     enter(i2cmbe_pkg::PH_TA_DATA, 1'b0);
                  else enter(i2cmbe_pkg::PH_RX_CLKHI, 1'b1);
               end
               i2cmbe_pkg::PH_TA_DATA: begin
                  sda_drive = !nack_pending;
                  enter(i2cmbe_pkg::PH_TA_CLKHI, 1'b0);
               end
               i2cmbe_pkg::PH_TA_CLKHI: begin
                  scl_drive = 1'b0;
                  enter(i2cmbe_pkg::PH_TA_CLKLO, 1'b1);
               end
               i2cmbe_pkg::PH_TA_CLKLO: begin
                  scl_drive = 1'b1;
                  enter(i2cmbe_pkg::PH_TA_END, 1'b1);
               end
               i2cmbe_pkg::PH_TA_END: begin
                  sda_drive   = 1'b1;
                  o.done_res  = 1'b1;
                  o.read_data = shift_reg;
                  enter(i2cmbe_pkg::PH_IDLE, 1'b0);
               end
               i2cmbe_pkg::PH_SP_SCL: begin
                  scl_drive = 1'b0;
                  enter(i2cmbe_pkg::PH_SP_SDA, 1'b1);
               end
               i2cmbe_pkg::PH_SP_SDA: begin
                  sda_drive = 1'b0;
                  enter(i2cmbe_pkg::PH_SP_END, 1'b1);
               end
               i2cmbe_pkg::PH_SP_END: begin
                  o.done_res = 1'b1;
                  enter(i2cmbe_pkg::PH_IDLE, 1'b0);
               end
               default: enter(i2cmbe_pkg::PH_IDLE, 1'b0);
            endcase
         end
         o.scl_low  = scl_drive;
         o.sda_low  = sda_drive;
         o.busy_res = (phase != i2cmbe_pkg::PH_IDLE);
         return o;
      endfunction

      function void note_tick(i2cmbe_pkg::req_item_type r);
         bus_outputs_q.push_back(advance_tick(r));
      endfunction

      function void check_output(i2cmbe_pkg::rsp_item_type got);
         i2cmbe_pkg::rsp_item_type want;
         if (bus_outputs_q.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = bus_outputs_q.pop_front();
         if (want !== got) begin
            $display("%0t: response mismatch: expected %h, actual %h", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we = 1'b0;
   logic [i2cmbe_pkg::CFG_WIDTH-1:0] csr_wdata = '0;

   int req_idle_pct   = 0;
   int rsp_stall_pct  = 0;
   int hold_cycles    = 0;
   int noise_pct      = 0;
   int ticks_sent     = 0;

   engine_shadow sb = new();

   i2cmbe_req_if req_if ();
   i2cmbe_rsp_if rsp_if ();

   i2c_master_byte_engine_unit #(
      .DELAY_WIDTH(10)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_if),
      .rsp_ch   (rsp_if),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic i2cmbe_pkg::req_item_type make_tick(logic v, logic [1:0] t,
                                                          logic [7:0] b, logic rf,
                                                          logic lb, logic sda);
      i2cmbe_pkg::req_item_type it;
      it.cmd_valid = v;
      it.req_type  = t;
      it.cmd_byte  = b;
      it.read_flag = rf;
      it.last_byte = lb;
      it.sda_in    = sda;
      return it;
   endfunction

   // 0 holds the line low, 1 leaves it high, anything else is random per tick
   function automatic logic sda_level(int sel);
      if (sel == 0) return 1'b0;
      if (sel == 1) return 1'b1;
      return 1'($urandom_range(1));
   endfunction

   task automatic send_tick(input i2cmbe_pkg::req_item_type it);
      if (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= it;
      do @(posedge clock); while (!req_if.ready);
      sb.note_tick(it);
      ticks_sent++;
   endtask

   // issue one command from idle, then keep ticking until the sequencer is idle again
   task automatic run_command(input logic [1:0] t, input logic [7:0] b, input logic rf,
                              input logic lb, input int sda_sel);
      i2cmbe_pkg::req_item_type busy_tick;
      send_tick(make_tick(1'b1, t, b, rf, lb, sda_level(sda_sel)));
      while (sb.phase != i2cmbe_pkg::PH_IDLE) begin
         // commands offered while busy should be dropped by the block
         busy_tick = make_tick($urandom_range(99) < noise_pct, 2'($urandom_range(3)),
                               8'($urandom_range(255)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), sda_level(sda_sel));
         send_tick(busy_tick);
      end
   endtask

   task automatic set_bit_delay(input logic [i2cmbe_pkg::CFG_WIDTH-1:0] v);
      req_if.valid <= 1'b0;
      while (sb.bus_outputs_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.bit_delay = v;
   endtask

   task automatic random_transaction();
      int   n;
      int   sda_sel;
      logic rd;
      sda_sel = $urandom_range(2);
      if ($urandom_range(99) < 80) begin
         rd = 1'($urandom_range(1));
         n  = $urandom_range(1, 2);
         run_command(i2cmbe_pkg::CMD_START, 8'($urandom_range(255)), rd,
                     1'($urandom_range(1)), sda_sel);
         for (int i = 0; i < n; i++) begin
            if (rd) run_command(i2cmbe_pkg::CMD_READ, 8'($urandom_range(255)),
                                1'($urandom_range(1)), (i == n - 1), sda_sel);
            else run_command(i2cmbe_pkg::CMD_WRITE, 8'($urandom_range(255)),
                             1'($urandom_range(1)), 1'($urandom_range(1)), sda_sel);
         end
         // now and then the stop is left out, so the next start is a repeated one
         if ($urandom_range(9) != 0)
            run_command(i2cmbe_pkg::CMD_STOP, 8'($urandom_range(255)),
                        1'($urandom_range(1)), 1'($urandom_range(1)), sda_sel);
      end else begin
         run_command(2'($urandom_range(3)), 8'($urandom_range(255)),
                     1'($urandom_range(1)), 1'($urandom_range(1)), sda_sel);
      end
      if ($urandom_range(99) < 20) begin
         repeat ($urandom_range(1, 4))
            send_tick(make_tick(1'b0, 2'($urandom_range(3)), 8'($urandom_range(255)),
                                1'($urandom_range(1)), 1'($urandom_range(1)),
                                1'($urandom_range(1))));
      end
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct,
                            input logic [i2cmbe_pkg::CFG_WIDTH-1:0] delay, input int hold,
                            input int target);
      int start_ticks;
      set_bit_delay(delay);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      hold_cycles   = hold;
      start_ticks   = ticks_sent;
      while (ticks_sent - start_ticks < target) random_transaction();
   endtask

   // response side: check every accepted response, stall at random
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) sb.check_output(rsp_if.data);
         if (hold_cycles > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of bit_delay
      run_command(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 2);

      // zero delay still holds each timed phase for one tick
      set_bit_delay('0);
      run_command(i2cmbe_pkg::CMD_START, 8'hFF, 1'b1, 1'b0, 0);
      run_command(i2cmbe_pkg::CMD_READ, 8'h00, 1'b0, 1'b0, 1);
      run_command(i2cmbe_pkg::CMD_READ, 8'hFF, 1'b1, 1'b1, 0);
      // start with both lines driven low
      run_command(i2cmbe_pkg::CMD_START, 8'h55, 1'b0, 1'b1, 2);
      noise_pct = 100;
      run_command(i2cmbe_pkg::CMD_WRITE, 8'hA5, 1'b0, 1'b0, 1);
      noise_pct = 0;
      run_command(i2cmbe_pkg::CMD_STOP, 8'hFF, 1'b1, 1'b1, 2);
      run_command(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 2);

      set_bit_delay(10'd1);
      run_command(i2cmbe_pkg::CMD_WRITE, 8'h3C, 1'b1, 1'b1, 0);
      run_command(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 2);

      set_bit_delay(10'd30);
      run_command(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, 1'b0, 0);

      noise_pct = 15;
      run_phase(0, 0, 10'd0, 0, 90);
      run_phase(81, 0, 10'd2, 0, 90);
      // long receiver hold while requests keep coming
      run_phase(0, 81, 10'd1, 300, 90);
      run_phase(35, 35, 10'($urandom_range(2, 4)), 0, 90);
      run_phase(0, 0, 10'd0, 0, 90);

      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      req_if.valid <= 1'b0;
      while (sb.bus_outputs_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.bus_outputs_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

// ===== i2c_master_byte_engine_unit.f =====
sv/i2cmbe_pkg.sv
sv/i2cmbe_req_if.sv
sv/i2cmbe_rsp_if.sv
sv/i2cmbe_seq.sv
sv/i2c_master_byte_engine_unit.sv
tb/i2c_master_byte_engine_unit_tb.sv
